@@ hdl/fpc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpc_pkg : shared constants and types for the float to PCM16 converter
// Format codes, register indexes and the lane control type.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PcmW  = 16;
  localparam int unsigned CfgW  = 2;
  localparam int unsigned IdxW  = 1;

  localparam logic [CfgW-1:0] FMT_FLOAT = 2'd0;
  localparam logic [CfgW-1:0] FMT_PCM16 = 2'd1;

  localparam logic [IdxW-1:0] REG_SAMPLE_FORMAT = 1'b0;
  localparam logic [IdxW-1:0] REG_OUT_CHANNELS  = 1'b1;

  // IEEE single 32767.0
  localparam logic [31:0] SCALE_BITS = 32'h46FF_FE00;

  typedef struct packed {
    logic            is_float;
    logic            is_pcm;
    logic            mono;
  } lane_ctl_t;

endpackage : fpc_pkg

`default_nettype wire

@@ hdl/float_to_pcm16_frame_converter.sv @@
// ----------------------------------------------------------------------------
// float_to_pcm16_frame_converter : stereo float32/PCM16 to PCM16 converter
// Two parallel lanes; mono zeroes the right lane; end marks piped alongside.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with left_bits, right_bits, silent and last_in_packet; the
//   frame is taken on any edge with start high (busy is always low).
//   done strobes for one cycle with left_pcm, right_pcm and last_out once
//   the frame has passed the lane multiply stage and the rounding stage.
//   One frame per cycle is sustained.
//   Registers: index 0 sample_format, index 1 out_channels; write via cfg_we,
//   cfg_addr, cfg_data while idle.
//   Reset clears the pipeline valid bits and loads format float32, stereo.
//   The receiver cannot stall; results are presented exactly once.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_pcm16_frame_converter import fpc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WordW-1:0] left_bits,
  input  wire logic [WordW-1:0] right_bits,
  input  wire logic             silent,
  input  wire logic             last_in_packet,
  input  wire logic             cfg_we,
  input  wire logic [IdxW-1:0]  cfg_addr,
  input  wire logic [CfgW-1:0]  cfg_data,
  output logic                  done,
  output logic      [PcmW-1:0]  left_pcm,
  output logic      [PcmW-1:0]  right_pcm,
  output logic                  last_out
);

  logic [CfgW-1:0] sample_format;
  logic [CfgW-1:0] out_channels;
  logic [1:0]      vld;
  logic [1:0]      last_pipe;
  lane_ctl_t       ctl;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_FLOAT;
      out_channels  <= 2'd2;
      vld           <= '0;
    end else begin
      if (cfg_we && cfg_addr == REG_SAMPLE_FORMAT) sample_format <= cfg_data;
      if (cfg_we && cfg_addr == REG_OUT_CHANNELS)  out_channels  <= cfg_data;
      vld <= {vld[0], start};
    end
    last_pipe <= {last_pipe[0], last_in_packet};
  end

  always_comb begin
    ctl.is_float = (sample_format == FMT_FLOAT);
    ctl.is_pcm   = (sample_format == FMT_PCM16);
    ctl.mono     = (out_channels < 2'd2);
  end

  logic zero_l, zero_r;
  assign zero_l = silent || !(ctl.is_float || ctl.is_pcm);
  assign zero_r = zero_l || ctl.mono;

  fpc_lane u_left (
    .clk(clk), .en(start), .zero(zero_l), .is_float(ctl.is_float),
    .word(left_bits), .pcm(left_pcm)
  );

  fpc_lane u_right (
    .clk(clk), .en(start), .zero(zero_r), .is_float(ctl.is_float),
    .word(right_bits), .pcm(right_pcm)
  );

  assign done     = vld[1];
  assign last_out = last_pipe[1];

  a_lat: assert property (@(posedge clk) disable iff (rst) start |=> ##1 done)
    else $error("missing result beat");
  a_nostart: assert property (@(posedge clk) disable iff (rst)
    (!$past(start, 2) && !$past(rst, 2) && !$past(rst)) |-> !done)
    else $error("spurious result beat");

endmodule : float_to_pcm16_frame_converter

`default_nettype wire

@@ hdl/fpc_lane.sv @@
// ----------------------------------------------------------------------------
// fpc_lane : one-channel converter
// Two-stage pipe: 24x24 mantissa multiply, then single-precision rounding,
// clamp, round half away from zero and truncate to 16 bits; PCM16 passes raw.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_lane import fpc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             zero,
  input  wire logic             is_float,
  input  wire logic [WordW-1:0] word,
  output logic      [PcmW-1:0]  pcm
);

  // stage 1 registers
  logic [47:0] prod;
  logic        sgn;
  logic [8:0]  exp1;
  logic        nan1;
  logic        inf1;
  logic        zr1;
  logic        flt1;
  logic [PcmW-1:0] raw1;

  logic [7:0]  e_in;
  logic [23:0] m_in;

  assign e_in = word[30:23];
  assign m_in = {(e_in != 8'd0), word[22:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 48'(m_in) * 48'({1'b1, SCALE_BITS[22:0]});
      sgn  <= word[31];
      exp1 <= {1'b0, e_in};
      nan1 <= (e_in == 8'hFF) && (word[22:0] != 23'd0);
      inf1 <= (e_in == 8'hFF) && (word[22:0] == 23'd0);
      zr1  <= zero;
      flt1 <= is_float;
      raw1 <= word[PcmW-1:0];
    end
  end

  // stage 2: value = prod * 2^(exp-159); find the integer part.
  // s = m*M * 2^(e-150+14-23); product bits 47:0 scale 2^(e-150-9)
  // normalised product has 24 significant bits; round to nearest even.
  logic        top;
  logic [23:0] sig;
  logic        g, st;
  logic [24:0] sig_r;
  logic signed [11:0] ex;     // exponent of bit 0 of sig_r
  logic [24:0] ip;            // integer magnitude after +0.5 and truncate
  logic [25:0] half_sum;
  logic [7:0]  sh;
  logic [PcmW-1:0] mag;
  logic [PcmW-1:0] res;

  always_comb begin
    top = prod[47];
    if (top) begin
      sig = prod[47:24];
      g   = prod[23];
      st  = |prod[22:0];
    end else begin
      sig = prod[46:23];
      g   = prod[22];
      st  = |prod[21:0];
    end
    sig_r = {1'b0, sig} + 25'((g && (st || sig[0])) ? 1 : 0);
    // m_in LSB weight 2^(e-150) (e>=1), scale LSB weight 2^-9 -> prod LSB 2^(e-159)
    ex = $signed({3'b0, (exp1 == 9'd0) ? 9'd1 : exp1}) - 12'sd159
         + (top ? 12'sd24 : 12'sd23);
    ip = 25'd0;
    half_sum = 26'd0;
    sh = 8'd0;
    // Magnitude clamp: positive ip >= 32767 gives 7FFF; negative ip >= 32768 gives 8000.
    if (ex >= 12'sd0) begin
      ip = 25'h1FF_FFFF;          // far above range
    end else if (ex > -12'sd26) begin
      sh = 8'(-ex);
      // 0.5 is 2^(sh-1) in units of bit 0; truncating the exact sum matches
      // the single-precision sum except just below one half
      half_sum = {1'b0, sig_r} + (26'd1 << (sh - 8'd1));
      ip = 25'(half_sum >> sh);
      if (ex == -12'sd25 && sig_r == 25'h0FF_FFFF) begin
        // 0.5 - 2^-25 plus 0.5 is a tie in single precision, rounds up to 1
        ip = 25'd1;
      end
    end
    if (inf1 || ip >= 25'd32767) begin
      mag = sgn ? 16'h8000 : 16'h7FFF;
    end else begin
      mag = ip[PcmW-1:0];
    end
    if (inf1 || ip >= 25'd32767)
      res = mag;
    else
      res = sgn ? PcmW'(-mag) : mag;
    if (ip >= 25'd32768 || inf1) res = sgn ? 16'h8000 : 16'h7FFF;
    else if (ip == 25'd32767) res = sgn ? 16'h8001 : 16'h7FFF;
  end

  always_ff @(posedge clk) begin
    if (zr1 || (flt1 && nan1))
      pcm <= '0;
    else if (flt1)
      pcm <= res;
    else
      pcm <= raw1;
  end

endmodule : fpc_lane

`default_nettype wire

@@ verif/float_to_pcm16_frame_converter_tb.sv @@
// ----------------------------------------------------------------------------
// float_to_pcm16_frame_converter_tb : self-checking bench for the converter
// Drives frames in random bursts across every format and channel setting.
// An exact single-precision predictor models the scale, clamp and rounding
// steps. A scoreboard checks each strobed result against the oldest expected
// frame.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_pcm16_frame_converter_tb;
  import fpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PcmW-1:0] left;
    logic [PcmW-1:0] right;
    logic            last;
  } pcm_frame_t;

  class pcm_scoreboard;
    logic [CfgW-1:0] fmt;
    logic [CfgW-1:0] chans;
    pcm_frame_t      pending[$];
    int              errors;
    int              checked;
    int              notes;

    function new();
      fmt = FMT_FLOAT;
      chans = 2'd2;
      errors = 0;
      checked = 0;
      notes = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
      if (idx == REG_SAMPLE_FORMAT) fmt = val;
      else chans = val;
    endfunction

    // round to 24 significant bits, ties to even, in the same units
    function automatic logic [191:0] round_single(logic [191:0] x);
      int width;
      int sh;
      logic [191:0] keep;
      logic [191:0] rem;
      logic [191:0] halfv;
      width = 0;
      for (int i = 191; i >= 0; i--) begin
        if (x[i]) begin
          width = i + 1;
          break;
        end
      end
      if (width <= 24) return x;
      sh = width - 24;
      keep = x >> sh;
      rem = x - (keep << sh);
      halfv = 192'd1 << (sh - 1);
      if (rem > halfv || (rem == halfv && keep[0])) keep = keep + 1;
      return keep << sh;
    endfunction

    function automatic logic [PcmW-1:0] float_to_pcm(logic [WordW-1:0] w);
      logic [191:0] prod;
      logic [191:0] sum;
      logic [23:0]  mant;
      logic [PcmW-1:0] mag;
      int n;
      if (w[30:23] == 8'hFF) begin
        if (w[22:0] != 0) return '0;
        return w[31] ? 16'h8000 : 16'h7FFF;
      end
      if (w[30:23] == 8'h00) begin
        mant = {1'b0, w[22:0]};
        n = 149;
      end else begin
        mant = {1'b1, w[22:0]};
        n = 150 - int'(w[30:23]);
      end
      // product in units of 2^-n
      prod = round_single(192'(mant) * 192'd32767);
      if (n <= 0) return w[31] ? 16'h8000 : 16'h7FFF;
      if (!w[31] && prod >= (192'd32767 << n)) return 16'h7FFF;
      if (w[31] && prod >= (192'd32768 << n)) return 16'h8000;
      sum = round_single(prod + (192'd1 << (n - 1)));
      mag = 16'(sum >> n);
      return w[31] ? -mag : mag;
    endfunction

    function automatic logic [PcmW-1:0] convert(logic [WordW-1:0] w);
      if (fmt == FMT_FLOAT) return float_to_pcm(w);
      if (fmt == FMT_PCM16) return w[PcmW-1:0];
      return '0;
    endfunction

    function void note_frame(logic [WordW-1:0] l, logic [WordW-1:0] r,
                             logic sil, logic last);
      pcm_frame_t f;
      f.left = '0;
      f.right = '0;
      f.last = last;
      if (!sil) begin
        f.left = convert(l);
        if (chans >= 2) f.right = convert(r);
      end
      pending.push_back(f);
      notes++;
    endfunction

    function void check_frame(logic [PcmW-1:0] l, logic [PcmW-1:0] r, logic last);
      pcm_frame_t f;
      if (pending.size() == 0) begin
        $error("unexpected result beat: left_pcm %0d right_pcm %0d", $signed(l),
               $signed(r));
        errors++;
        return;
      end
      f = pending.pop_front();
      checked++;
      if (l !== f.left) begin
        $error("left_pcm expected %0d actual %0d", $signed(f.left), $signed(l));
        errors++;
      end
      if (r !== f.right) begin
        $error("right_pcm expected %0d actual %0d", $signed(f.right), $signed(r));
        errors++;
      end
      if (last !== f.last) begin
        $error("last_out expected %0b actual %0b", f.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int LatencyWait = 6;
  localparam int StallLimit  = 2000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [WordW-1:0] left_bits;
  logic [WordW-1:0] right_bits;
  logic             silent;
  logic             last_in_packet;
  logic             cfg_we;
  logic [IdxW-1:0]  cfg_addr;
  logic [CfgW-1:0]  cfg_data;
  logic             done;
  logic [PcmW-1:0]  left_pcm;
  logic [PcmW-1:0]  right_pcm;
  logic             last_out;

  pcm_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  float_to_pcm16_frame_converter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .left_bits(left_bits), .right_bits(right_bits), .silent(silent),
    .last_in_packet(last_in_packet), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data), .done(done), .left_pcm(left_pcm),
    .right_pcm(right_pcm), .last_out(last_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy)
        sb.note_frame(left_bits, right_bits, silent, last_in_packet);
      if (cfg_we) sb.set_reg(cfg_addr, cfg_data);
      if (done) sb.check_frame(left_pcm, right_pcm, last_out);
      if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_frame(logic [WordW-1:0] l, logic [WordW-1:0] r,
                            logic sil, logic last);
    logic held;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // some bursts follow on with no gap at all
      if ($urandom_range(0, 9) < 7) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    left_bits <= l;
    right_bits <= r;
    silent <= sil;
    last_in_packet <= last;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LatencyWait) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] rand_float();
    logic [WordW-1:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: ;
      1: w[30:23] = 8'hFF;
      2: w[30:23] = 8'h00;
      3: w[30:0] = $urandom_range(0, 1) ? 31'h7F80_0000 : 31'h0;
      default: w[30:23] = 8'($urandom_range(100, 144));
    endcase
    return w;
  endfunction

  function automatic logic rand_bit(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  logic [WordW-1:0] edge_words[$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'hFF80_0001, 32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000, 32'h7F7F_FFFF,
    32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h3EFF_FFFF, 32'hBEFF_FFFF,
    32'h3800_0100, 32'hB800_0100, 32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0000_8000
  };

  logic [CfgW-1:0] phase_fmt[9]   = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1};
  logic [CfgW-1:0] phase_chans[9] = '{2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd0};

  initial begin
    logic [WordW-1:0] l;
    logic [WordW-1:0] r;
    rst = 1'b1;
    start = 1'b0;
    left_bits = '0;
    right_bits = '0;
    silent = 1'b0;
    last_in_packet = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: float, stereo
    foreach (edge_words[i])
      send_frame(edge_words[i], edge_words[edge_words.size() - 1 - i], 1'b0, i[0]);
    send_frame(32'h3F80_0000, 32'hBF80_0000, 1'b1, 1'b1);
    send_frame(32'h7F80_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);

    foreach (phase_fmt[p]) begin
      write_reg(REG_SAMPLE_FORMAT, phase_fmt[p]);
      write_reg(REG_OUT_CHANNELS, phase_chans[p]);
      for (int k = 0; k < 5; k++)
        send_frame(edge_words[k * 4 + 1], edge_words[19 - k * 3], 1'b0, k[0]);
      for (int k = 0; k < 200; k++) begin
        if (phase_fmt[p] == FMT_FLOAT) begin
          l = rand_float();
          r = rand_float();
        end else begin
          l = $urandom();
          r = $urandom();
        end
        send_frame(l, r, rand_bit(10), rand_bit(20));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LatencyWait) @(posedge clk);

    $display("Frames sent %0d, results checked %0d, over 10 format/channel settings",
             sb.notes, sb.checked);
    $display("Mismatches seen: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : float_to_pcm16_frame_converter_tb

`default_nettype wire
